@@ design/rrpw_pkg.sv @@
// Shared types and constants for the rounded rectangle pixel writer.
`default_nettype none

package rrpw_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int ADDR_W         = 32;
	localparam int COLOR_W        = 32;
	localparam int PITCH_W        = 16;
	localparam int SROWS_W        = 12;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 32;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BUFFER_BASE = 2'd0,
		REG_ROW_PITCH   = 2'd1,
		REG_SCREEN_ROWS = 2'd2
	} cfg_reg_t;

	// Input word kind, carried on tuser
	typedef enum logic {
		ACT_START   = 1'b0,
		ACT_ADVANCE = 1'b1
	} action_t;

	// Per-word control that rides along the pipeline
	typedef struct packed {
		logic pixel;        // advance step with an active scan: candidate write
		logic last;         // final pixel step, or nothing active
		logic near_left;
		logic near_right;
		logic near_top;
		logic near_bottom;
	} step_ctl_t;

endpackage

`default_nettype wire

@@ design/rounded_rect_pixel_writer_top.sv @@
// Top level of the rounded rectangle pixel writer: ports, config registers, pipeline.
`default_nettype none

// Rounded rectangle pixel writer. A start word (tuser 0) latches the rectangle and
// resets the raster scan; each advance word (tuser 1) visits one pixel, left to right,
// top to bottom, and yields exactly one output word: a pixel write (tuser 1) with its
// back-buffer byte address, or a skipped step (tuser 0, address and data zero). tlast
// marks the final pixel of a rectangle, an empty start, or an advance with nothing
// active. One word is taken per clock unless the output stalls; the only loop is the
// scan counter update at the input, so throughput is one word per cycle while m_tready
// holds. Three register stages: offsets at the input stage, squarers and the row-pitch
// multiplier in the second, corner compares and the address sum into the output
// register. Write configuration only while idle.
module rounded_rect_pixel_writer_top #(
	parameter int COORD_BITS  = rrpw_pkg::COORD_BITS_DEF,
	parameter int IN_TDATA_W  = ((5 * COORD_BITS - 1 + rrpw_pkg::COLOR_W + 7) / 8) * 8
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	// left, top, span_x, span_y, corner_radius, fill_color, zero pad
	input  wire  [IN_TDATA_W-1:0]           s_tdata,
	// action
	input  wire                             s_tuser,
	output logic                            m_tvalid,
	input  wire                             m_tready,
	// write_address, write_data
	output logic [63:0]                     m_tdata,
	// write_valid
	output logic                            m_tuser,
	output logic                            m_tlast,
	input  wire                             cfg_we,
	input  wire  [rrpw_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire  [rrpw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rrpw_pkg::*;

	localparam int C = COORD_BITS;

	logic [ADDR_W-1:0]  buffer_base_q;
	logic [PITCH_W-1:0] row_pitch_q;
	logic [SROWS_W-1:0] screen_rows_q;

	logic                  valid_s1, ready_s2, valid_s2, ready_s3;
	step_ctl_t             ctl_s1, ctl_s2;
	logic signed [C+1:0]   ax_l_s1, ax_r_s1, ay_t_s1, ay_b_s1;
	logic [C-2:0]          radius_s1;
	logic [C:0]            col_s1, row_s1, col_s2;
	logic [COLOR_W-1:0]    color_s1, color_s2;
	logic [2*C+3:0]        sq_l_s2, sq_r_s2, sq_t_s2, sq_b_s2;
	logic [2*C-3:0]        r2_s2;
	logic [ADDR_W-1:0]     prod_s2;
	logic [ADDR_W-1:0]     write_address_s3;
	logic [COLOR_W-1:0]    write_data_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_base_q <= '0;
			row_pitch_q   <= '0;
			screen_rows_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BUFFER_BASE: buffer_base_q <= cfg_data[ADDR_W-1:0];
				REG_ROW_PITCH:   row_pitch_q   <= cfg_data[PITCH_W-1:0];
				REG_SCREEN_ROWS: screen_rows_q <= cfg_data[SROWS_W-1:0];
				default: ;
			endcase
		end
	end

	rrpw_scan #(.COORD_BITS(COORD_BITS)) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.action        (s_tuser),
		.left          (s_tdata[C-1:0]),
		.top           (s_tdata[2*C-1:C]),
		.span_x        (s_tdata[3*C-1:2*C]),
		.span_y        (s_tdata[4*C-1:3*C]),
		.corner_radius (s_tdata[5*C-2:4*C]),
		.fill_color    (s_tdata[5*C-2+COLOR_W:5*C-1]),
		.valid_s1      (valid_s1),
		.ready_s2      (ready_s2),
		.ctl_s1        (ctl_s1),
		.ax_l_s1       (ax_l_s1),
		.ax_r_s1       (ax_r_s1),
		.ay_t_s1       (ay_t_s1),
		.ay_b_s1       (ay_b_s1),
		.radius_s1     (radius_s1),
		.col_s1        (col_s1),
		.row_s1        (row_s1),
		.color_s1      (color_s1)
	);

	rrpw_square #(.COORD_BITS(COORD_BITS)) u_square (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.ready_s2    (ready_s2),
		.ctl_s1      (ctl_s1),
		.ax_l_s1     (ax_l_s1),
		.ax_r_s1     (ax_r_s1),
		.ay_t_s1     (ay_t_s1),
		.ay_b_s1     (ay_b_s1),
		.radius_s1   (radius_s1),
		.col_s1      (col_s1),
		.row_s1      (row_s1),
		.color_s1    (color_s1),
		.screen_rows (screen_rows_q),
		.row_pitch   (row_pitch_q),
		.valid_s2    (valid_s2),
		.ready_s3    (ready_s3),
		.ctl_s2      (ctl_s2),
		.sq_l_s2     (sq_l_s2),
		.sq_r_s2     (sq_r_s2),
		.sq_t_s2     (sq_t_s2),
		.sq_b_s2     (sq_b_s2),
		.r2_s2       (r2_s2),
		.prod_s2     (prod_s2),
		.col_s2      (col_s2),
		.color_s2    (color_s2)
	);

	rrpw_emit #(.COORD_BITS(COORD_BITS)) u_emit (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s2         (valid_s2),
		.ready_s3         (ready_s3),
		.ctl_s2           (ctl_s2),
		.sq_l_s2          (sq_l_s2),
		.sq_r_s2          (sq_r_s2),
		.sq_t_s2          (sq_t_s2),
		.sq_b_s2          (sq_b_s2),
		.r2_s2            (r2_s2),
		.prod_s2          (prod_s2),
		.col_s2           (col_s2),
		.color_s2         (color_s2),
		.buffer_base      (buffer_base_q),
		.valid_s3         (m_tvalid),
		.out_ready        (m_tready),
		.write_valid_s3   (m_tuser),
		.write_address_s3 (write_address_s3),
		.write_data_s3    (write_data_s3),
		.last_s3          (m_tlast)
	);

	assign m_tdata = {write_data_s3, write_address_s3};

endmodule

`default_nettype wire

@@ design/rrpw_scan.sv @@
// Rectangle and scan state, corner offsets and the first pipeline stage.
`default_nettype none

module rrpw_scan #(
	parameter int COORD_BITS = 12
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire                           action,
	input  wire  [COORD_BITS-1:0]         left,
	input  wire  [COORD_BITS-1:0]         top,
	input  wire  [COORD_BITS-1:0]         span_x,
	input  wire  [COORD_BITS-1:0]         span_y,
	input  wire  [COORD_BITS-2:0]         corner_radius,
	input  wire  [rrpw_pkg::COLOR_W-1:0]  fill_color,
	output logic                          valid_s1,
	input  wire                           ready_s2,
	output rrpw_pkg::step_ctl_t           ctl_s1,
	output logic signed [COORD_BITS+1:0]  ax_l_s1,
	output logic signed [COORD_BITS+1:0]  ax_r_s1,
	output logic signed [COORD_BITS+1:0]  ay_t_s1,
	output logic signed [COORD_BITS+1:0]  ay_b_s1,
	output logic [COORD_BITS-2:0]         radius_s1,
	output logic [COORD_BITS:0]           col_s1,
	output logic [COORD_BITS:0]           row_s1,
	output logic [rrpw_pkg::COLOR_W-1:0]  color_s1
);
	import rrpw_pkg::*;

	localparam int C   = COORD_BITS;
	localparam int D_W = COORD_BITS + 2;

	logic [C-1:0]       rect_left_q;
	logic [C-1:0]       rect_top_q;
	logic [C-1:0]       rect_width_q;
	logic [C-1:0]       rect_height_q;
	logic [C-2:0]       rect_radius_q;
	logic [COLOR_W-1:0] rect_color_q;
	logic [C-1:0]       scan_col_q;
	logic [C-1:0]       scan_row_q;
	logic               scan_active_q;

	logic               accept;
	logic               is_start;
	logic               empty_in;
	logic signed [D_W-1:0] dx_e, dy_e, r_e, wr_e, hr_e;
	logic               col_end, row_end;
	step_ctl_t          ctl_d;

	assign in_ready = !valid_s1 || ready_s2;
	assign accept   = in_valid && in_ready;
	assign is_start = (action == ACT_START);
	assign empty_in = (span_x == '0) || (span_y == '0);

	// Offsets from the corner centers, all in signed arithmetic
	assign dx_e = $signed({2'b00, scan_col_q});
	assign dy_e = $signed({2'b00, scan_row_q});
	assign r_e  = $signed({3'b000, rect_radius_q});
	assign wr_e = $signed({2'b00, rect_width_q}) - r_e;
	assign hr_e = $signed({2'b00, rect_height_q}) - r_e;

	// End of row and end of rectangle
	assign col_end = ({1'b0, scan_col_q} + (C+1)'(1)) >= {1'b0, rect_width_q};
	assign row_end = ({1'b0, scan_row_q} + (C+1)'(1)) >= {1'b0, rect_height_q};

	// Control for the word being accepted
	always_comb begin
		ctl_d             = '0;
		ctl_d.near_left   = dx_e < r_e;
		ctl_d.near_top    = dy_e < r_e;
		ctl_d.near_right  = dx_e > wr_e;
		ctl_d.near_bottom = dy_e > hr_e;
		if (is_start) begin
			ctl_d.last = empty_in;
		end else if (!scan_active_q) begin
			ctl_d.last = 1'b1;
		end else begin
			ctl_d.pixel = 1'b1;
			ctl_d.last  = col_end && row_end;
		end
	end

	// Rectangle and raster scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_top_q    <= '0;
			rect_width_q  <= '0;
			rect_height_q <= '0;
			rect_radius_q <= '0;
			rect_color_q  <= '0;
			scan_col_q    <= '0;
			scan_row_q    <= '0;
			scan_active_q <= 1'b0;
		end else if (accept) begin
			if (is_start) begin
				rect_left_q   <= left;
				rect_top_q    <= top;
				rect_width_q  <= span_x;
				rect_height_q <= span_y;
				rect_radius_q <= corner_radius;
				rect_color_q  <= fill_color;
				scan_col_q    <= '0;
				scan_row_q    <= '0;
				scan_active_q <= !empty_in;
			end else if (scan_active_q) begin
				if (col_end) begin
					scan_col_q <= '0;
					if (row_end) begin
						scan_row_q    <= '0;
						scan_active_q <= 1'b0;
					end else begin
						scan_row_q <= scan_row_q + C'(1);
					end
				end else begin
					scan_col_q <= scan_col_q + C'(1);
				end
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1    <= ctl_d;
			ax_l_s1   <= dx_e - r_e;
			ax_r_s1   <= dx_e - wr_e;
			ay_t_s1   <= dy_e - r_e;
			ay_b_s1   <= dy_e - hr_e;
			radius_s1 <= rect_radius_q;
			col_s1    <= {1'b0, rect_left_q} + {1'b0, scan_col_q};
			row_s1    <= {1'b0, rect_top_q} + {1'b0, scan_row_q};
			color_s1  <= rect_color_q;
		end
	end

`ifndef ASSERT_OFF
	a_idle_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		!scan_active_q |-> (scan_col_q == '0) && (scan_row_q == '0))
		else $error("idle scan not at origin");

	a_scan_inside: assert property (@(posedge clk) disable iff (!arst_n)
		scan_active_q |-> (scan_col_q < rect_width_q) && (scan_row_q < rect_height_q))
		else $error("scan position outside rectangle");

	a_empty_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_start && empty_in |=> !scan_active_q)
		else $error("empty rectangle started a scan");
`endif

endmodule

`default_nettype wire

@@ design/rrpw_square.sv @@
// Second stage: corner offset squares, radius square and row address product.
`default_nettype none

module rrpw_square #(
	parameter int COORD_BITS = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            valid_s1,
	output logic                           ready_s2,
	input  wire rrpw_pkg::step_ctl_t       ctl_s1,
	input  wire signed [COORD_BITS+1:0]    ax_l_s1,
	input  wire signed [COORD_BITS+1:0]    ax_r_s1,
	input  wire signed [COORD_BITS+1:0]    ay_t_s1,
	input  wire signed [COORD_BITS+1:0]    ay_b_s1,
	input  wire  [COORD_BITS-2:0]          radius_s1,
	input  wire  [COORD_BITS:0]            col_s1,
	input  wire  [COORD_BITS:0]            row_s1,
	input  wire  [rrpw_pkg::COLOR_W-1:0]   color_s1,
	input  wire  [rrpw_pkg::SROWS_W-1:0]   screen_rows,
	input  wire  [rrpw_pkg::PITCH_W-1:0]   row_pitch,
	output logic                           valid_s2,
	input  wire                            ready_s3,
	output rrpw_pkg::step_ctl_t            ctl_s2,
	output logic [2*COORD_BITS+3:0]        sq_l_s2,
	output logic [2*COORD_BITS+3:0]        sq_r_s2,
	output logic [2*COORD_BITS+3:0]        sq_t_s2,
	output logic [2*COORD_BITS+3:0]        sq_b_s2,
	output logic [2*COORD_BITS-3:0]        r2_s2,
	output logic [rrpw_pkg::ADDR_W-1:0]    prod_s2,
	output logic [COORD_BITS:0]            col_s2,
	output logic [rrpw_pkg::COLOR_W-1:0]   color_s2
);
	import rrpw_pkg::*;

	localparam int SQ_W   = 2 * COORD_BITS + 4;
	localparam int R2_W   = 2 * COORD_BITS - 2;
	localparam int ROW_W  = ((COORD_BITS + 1 > SROWS_W) ? COORD_BITS + 1 : SROWS_W) + 1;
	localparam int PROD_W = ROW_W + PITCH_W;

	logic               accept;
	logic signed [SQ_W-1:0] sq_l_d, sq_r_d, sq_t_d, sq_b_d;
	logic [R2_W-1:0]    r2_d;
	logic [ROW_W-1:0]   row_sum;
	logic [PROD_W-1:0]  prod_full;

	assign ready_s2 = !valid_s2 || ready_s3;
	assign accept   = valid_s1 && ready_s2;

	// Squares of the corner offsets
	assign sq_l_d = ax_l_s1 * ax_l_s1;
	assign sq_r_d = ax_r_s1 * ax_r_s1;
	assign sq_t_d = ay_t_s1 * ay_t_s1;
	assign sq_b_d = ay_b_s1 * ay_b_s1;
	assign r2_d   = radius_s1 * radius_s1;

	// Back buffer row times pitch
	assign row_sum   = ROW_W'(row_s1) + ROW_W'(screen_rows);
	assign prod_full = row_sum * row_pitch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s2   <= ctl_s1;
			sq_l_s2  <= $unsigned(sq_l_d);
			sq_r_s2  <= $unsigned(sq_r_d);
			sq_t_s2  <= $unsigned(sq_t_d);
			sq_b_s2  <= $unsigned(sq_b_d);
			r2_s2    <= r2_d;
			prod_s2  <= ADDR_W'(prod_full);
			col_s2   <= col_s1;
			color_s2 <= color_s1;
		end
	end

endmodule

`default_nettype wire

@@ design/rrpw_emit.sv @@
// Output stage: corner rejection, write address sum and result register.
`default_nettype none

module rrpw_emit #(
	parameter int COORD_BITS = 12
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            valid_s2,
	output logic                           ready_s3,
	input  wire rrpw_pkg::step_ctl_t       ctl_s2,
	input  wire  [2*COORD_BITS+3:0]        sq_l_s2,
	input  wire  [2*COORD_BITS+3:0]        sq_r_s2,
	input  wire  [2*COORD_BITS+3:0]        sq_t_s2,
	input  wire  [2*COORD_BITS+3:0]        sq_b_s2,
	input  wire  [2*COORD_BITS-3:0]        r2_s2,
	input  wire  [rrpw_pkg::ADDR_W-1:0]    prod_s2,
	input  wire  [COORD_BITS:0]            col_s2,
	input  wire  [rrpw_pkg::COLOR_W-1:0]   color_s2,
	input  wire  [rrpw_pkg::ADDR_W-1:0]    buffer_base,
	output logic                           valid_s3,
	input  wire                            out_ready,
	output logic                           write_valid_s3,
	output logic [rrpw_pkg::ADDR_W-1:0]    write_address_s3,
	output logic [rrpw_pkg::COLOR_W-1:0]   write_data_s3,
	output logic                           last_s3
);
	import rrpw_pkg::*;

	localparam int SUM_W = 2 * COORD_BITS + 5;

	logic              accept;
	logic [SUM_W-1:0]  r2_e;
	logic              out_tl, out_bl, out_tr, out_br;
	logic              skip, wv;
	logic [ADDR_W-1:0] addr_d;

	assign ready_s3 = !valid_s3 || out_ready;
	assign accept   = valid_s2 && ready_s3;

	// Outside-the-arc tests for the four corners
	assign r2_e   = SUM_W'(r2_s2);
	assign out_tl = ctl_s2.near_left && ctl_s2.near_top &&
		((SUM_W'(sq_l_s2) + SUM_W'(sq_t_s2)) > r2_e);
	assign out_bl = ctl_s2.near_left && ctl_s2.near_bottom &&
		((SUM_W'(sq_l_s2) + SUM_W'(sq_b_s2)) > r2_e);
	assign out_tr = ctl_s2.near_right && ctl_s2.near_top &&
		((SUM_W'(sq_r_s2) + SUM_W'(sq_t_s2)) > r2_e);
	assign out_br = ctl_s2.near_right && ctl_s2.near_bottom &&
		((SUM_W'(sq_r_s2) + SUM_W'(sq_b_s2)) > r2_e);
	assign skip   = out_tl || out_bl || out_tr || out_br;
	assign wv     = ctl_s2.pixel && !skip;

	// Byte address in the back buffer, wrapping at 32 bits
	assign addr_d = buffer_base + prod_s2 + ADDR_W'({col_s2, 2'b00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			write_valid_s3   <= wv;
			write_address_s3 <= wv ? addr_d : '0;
			write_data_s3    <= wv ? color_s2 : '0;
			last_s3          <= ctl_s2.last;
		end
	end

`ifndef ASSERT_OFF
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !write_valid_s3 |-> (write_address_s3 == '0) && (write_data_s3 == '0))
		else $error("skipped step carries address or data");
`endif

endmodule

`default_nettype wire
